/* design/fpt_pkg.sv */
// Shared types, constants and helpers for the fractal pixel test block.
package fpt_pkg;

  localparam int MAX_DEPTH   = 6;
  localparam int COORD_W     = 10;
  localparam int CFG_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int KIND_W      = 2;
  localparam int CFG_DEPTH_W = 3;
  localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
  localparam int EDGE_W      = 16;

  // x / 3 == (x * 683) >> 11 for every 10-bit x
  localparam int RECIP_3  = 683;
  localparam int RECIP_SH = 11;

  localparam logic [CFG_IDX_W-1:0] REG_KIND  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_CARPET   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_VICSEK   = 2'd2
  } kind_e;

  // one word in flight through the cell chain
  typedef struct packed {
    kind_e               kind;
    logic [DEPTH_W-1:0]  levels;
    logic                fill;
    logic                outside;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
  } word_t;

  // edge length base^depth
  function automatic logic [EDGE_W-1:0] edge_len(kind_e kind, logic [DEPTH_W-1:0] d);
    int e;
    e = 1;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (i < int'(d)) begin
        e = (kind == KIND_TRIANGLE) ? e * 2 : e * 3;
      end
    end
    return EDGE_W'(e);
  endfunction

endpackage

/* design/fpt_cell.sv */
// One level of the digit test: peels one base digit off row and column.
module fpt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  fpt_pkg::word_t word_i,
  output logic           valid_o,
  output fpt_pkg::word_t word_o
);
  import fpt_pkg::*;

  logic                          valid_q;
  word_t                         word_q, word_d;
  logic [COORD_W+RECIP_SH-1:0]   prod_r, prod_c;
  logic [COORD_W-1:0]            q_r, q_c, m_r, m_c;
  logic [1:0]                    dig_r, dig_c;
  logic                          clear;

  always_comb begin
    prod_r = {{RECIP_SH{1'b0}}, word_i.row}    * (COORD_W+RECIP_SH)'(RECIP_3);
    prod_c = {{RECIP_SH{1'b0}}, word_i.column} * (COORD_W+RECIP_SH)'(RECIP_3);
    if (word_i.kind == KIND_TRIANGLE) begin
      q_r   = word_i.row >> 1;
      q_c   = word_i.column >> 1;
      m_r   = '0;
      m_c   = '0;
      dig_r = {1'b0, word_i.row[0]};
      dig_c = {1'b0, word_i.column[0]};
    end else begin
      q_r   = COORD_W'(prod_r >> RECIP_SH);
      q_c   = COORD_W'(prod_c >> RECIP_SH);
      m_r   = word_i.row    - COORD_W'(q_r * COORD_W'(3));
      m_c   = word_i.column - COORD_W'(q_c * COORD_W'(3));
      dig_r = m_r[1:0];
      dig_c = m_c[1:0];
    end

    case (word_i.kind)
      KIND_TRIANGLE: clear = dig_r[0] & dig_c[0];
      KIND_VICSEK:   clear = dig_r[0] ^ dig_c[0];   // odd digit sum
      default:       clear = (dig_r == 2'd1) && (dig_c == 2'd1);
    endcase

    word_d = word_i;
    if (word_i.levels != '0) begin
      word_d.levels = word_i.levels - DEPTH_W'(1);
      word_d.fill   = word_i.fill & ~clear;
      word_d.row    = q_r;
      word_d.column = q_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* design/fractal_pixel_test_unit.sv */
// Fractal pixel test top level: config registers, edge check, chain of level cells.
// Each word passes through MAX_DEPTH registered level cells from start to done_o, one cell per level.
// Throughput: one word per cycle; busy is never raised.
// Results appear on done_o for one cycle; the receiver cannot stall.
// Reset clears the chain's valid bits and sets kind to carpet, depth to 1.
module fractal_pixel_test_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fpt_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [fpt_pkg::COORD_W-1:0] row_i,
  input  logic [fpt_pkg::COORD_W-1:0] column_i,
  output logic                        done_o,
  output logic                        filled_o,
  output logic                        outside_o
);
  import fpt_pkg::*;

  logic [KIND_W-1:0]      kind_q, kind_d;
  logic [CFG_DEPTH_W-1:0] depth_q, depth_d;
  kind_e                  kind_eff;
  logic [DEPTH_W-1:0]     depth_eff;
  logic [EDGE_W-1:0]      edge_n;
  logic                   outside;

  logic  valid_chain [MAX_DEPTH+1];
  word_t word_chain  [MAX_DEPTH+1];

  always_comb begin
    kind_d  = kind_q;
    depth_d = depth_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KIND:  kind_d  = cfg_wdata_i[KIND_W-1:0];
        REG_DEPTH: depth_d = cfg_wdata_i[CFG_DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_W'(KIND_CARPET);
      depth_q <= CFG_DEPTH_W'(1);
    end else begin
      kind_q  <= kind_d;
      depth_q <= depth_d;
    end
  end

  always_comb begin
    case (kind_q)
      KIND_W'(KIND_TRIANGLE): kind_eff = KIND_TRIANGLE;
      KIND_W'(KIND_VICSEK):   kind_eff = KIND_VICSEK;
      default:                kind_eff = KIND_CARPET;
    endcase
    if (depth_q == '0) begin
      depth_eff = DEPTH_W'(1);
    end else if (int'(depth_q) > MAX_DEPTH) begin
      depth_eff = DEPTH_W'(MAX_DEPTH);
    end else begin
      depth_eff = DEPTH_W'(depth_q);
    end
    edge_n  = edge_len(kind_eff, depth_eff);
    outside = (EDGE_W'(row_i) >= edge_n) || (EDGE_W'(column_i) >= edge_n);
  end

  assign busy = 1'b0;

  assign valid_chain[0] = start & ~busy;
  assign word_chain[0]  = '{kind:    kind_eff,
                            levels:  depth_eff,
                            fill:    ~outside,
                            outside: outside,
                            row:     row_i,
                            column:  column_i};

  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    fpt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_chain[g]),
      .word_i  (word_chain[g]),
      .valid_o (valid_chain[g+1]),
      .word_o  (word_chain[g+1])
    );
  end

  assign done_o    = valid_chain[MAX_DEPTH];
  assign filled_o  = word_chain[MAX_DEPTH].fill;
  assign outside_o = word_chain[MAX_DEPTH].outside;

endmodule

/* tb/sv/tb_fractal_pixel_test_unit.sv */
// Self-checking testbench for the fractal pixel test unit: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_fractal_pixel_test_unit;
  import fpt_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int RANDOM_WORDS = 850;
  localparam int N_DIR = 27;

  typedef struct {
    logic filled;
    logic outside;
  } pixel_res_t;

  typedef enum bit {STEP_PIX, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e             op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     column;
    bit                     typed;
    logic                   filled;
    logic                   outside;
  } dir_step_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COORD_W-1:0]   row_i = '0;
  logic [COORD_W-1:0]   column_i = '0;
  logic                 done_o;
  logic                 filled_o;
  logic                 outside_o;

  // shadow of the block's registers
  logic [KIND_W-1:0]      kind_cfg = KIND_CARPET;
  logic [CFG_DEPTH_W-1:0] depth_cfg = 3'd1;

  pixel_res_t pixel_expect_q[$];
  int mismatch_cnt = 0;

  dir_step_t dir_steps [0:N_DIR-1] = '{
    // carpet, depth 1 after reset
    '{STEP_PIX, REG_KIND, 3'd0, 10'd0,    10'd0,    1'b1, 1'b1, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd1,    10'd1,    1'b1, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd2,    10'd2,    1'b1, 1'b1, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd3,    10'd0,    1'b1, 1'b0, 1'b1},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b1},
    // triangle, depth zero acts as one
    '{STEP_CFG, REG_KIND, CFG_W'(KIND_TRIANGLE), 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_CFG, REG_DEPTH, 3'd0, 10'd0,   10'd0,    1'b0, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd1,    10'd1,    1'b1, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd0,    10'd1,    1'b1, 1'b1, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd2,    10'd0,    1'b1, 1'b0, 1'b1},
    // depth 7 saturates to the max, for triangle and then vicsek
    '{STEP_CFG, REG_DEPTH, 3'd7, 10'd0,   10'd0,    1'b0, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd63,   10'd63,   1'b1, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd63,   10'd0,    1'b1, 1'b1, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd64,   10'd0,    1'b1, 1'b0, 1'b1},
    '{STEP_CFG, REG_KIND, CFG_W'(KIND_VICSEK), 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd728,  10'd728,  1'b1, 1'b1, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd728,  10'd0,    1'b1, 1'b1, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd1,    10'd0,    1'b1, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd729,  10'd0,    1'b1, 1'b0, 1'b1},
    // unused kind falls back to carpet
    '{STEP_CFG, REG_KIND, CFG_W'(KIND_UNUSED), 10'd0, 10'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd364,  10'd364,  1'b1, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd0,    10'd1023, 1'b1, 1'b0, 1'b1},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd728,  10'd728,  1'b1, 1'b1, 1'b0},
    // writes past the register list must not land
    '{STEP_CFG, REG_SPARE_A, 3'd7, 10'd0, 10'd0,    1'b0, 1'b0, 1'b0},
    '{STEP_CFG, REG_SPARE_B, 3'd5, 10'd0, 10'd0,    1'b0, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd13,   10'd13,   1'b0, 1'b0, 1'b0},
    '{STEP_PIX, REG_KIND, 3'd0, 10'd1,    10'd3,    1'b0, 1'b0, 1'b0}
  };

  fractal_pixel_test_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .busy       (busy),
    .row_i      (row_i),
    .column_i   (column_i),
    .done_o     (done_o),
    .filled_o   (filled_o),
    .outside_o  (outside_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // edge length for raw register values
  function automatic int pattern_span(logic [KIND_W-1:0] kind_raw,
                                      logic [CFG_DEPTH_W-1:0] depth_raw);
    int levels;
    int span;
    levels = (depth_raw == 0) ? 1 : (depth_raw > MAX_DEPTH) ? MAX_DEPTH : int'(depth_raw);
    span = 1;
    for (int i = 0; i < levels; i++) begin
      span = (kind_raw == KIND_TRIANGLE) ? span * 2 : span * 3;
    end
    return span;
  endfunction

  function automatic pixel_res_t predict_pixel(logic [KIND_W-1:0] kind_raw,
                                               logic [CFG_DEPTH_W-1:0] depth_raw,
                                               logic [COORD_W-1:0] r_in,
                                               logic [COORD_W-1:0] c_in);
    kind_e      kind;
    int         levels;
    int         base;
    int         span;
    int         r;
    int         c;
    pixel_res_t res;
    kind = (kind_raw == KIND_UNUSED) ? KIND_CARPET : kind_e'(kind_raw);
    levels = (depth_raw == 0) ? 1 : (depth_raw > MAX_DEPTH) ? MAX_DEPTH : int'(depth_raw);
    base = (kind == KIND_TRIANGLE) ? 2 : 3;
    span = pattern_span(kind_raw, depth_raw);
    r = int'(r_in);
    c = int'(c_in);
    res.outside = (r >= span) || (c >= span);
    res.filled = !res.outside;
    if (!res.outside) begin
      for (int i = 0; i < levels; i++) begin
        if (kind == KIND_VICSEK) begin
          if ((((r % base) + (c % base)) & 1) != 0) res.filled = 1'b0;
        end else if ((r % base) == 1 && (c % base) == 1) begin
          res.filled = 1'b0;
        end
        r = r / base;
        c = c / base;
      end
    end
    return res;
  endfunction

  // mostly inside the pattern, some on the edge, some anywhere in the field
  function automatic logic [COORD_W-1:0] pick_coord(int span);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 6) return COORD_W'($urandom_range(0, span - 1));
    if (mode == 7) return COORD_W'($urandom_range(span - 1, span));
    return COORD_W'($urandom);
  endfunction

  task automatic send_word(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                           pixel_res_t expected);
    row_i    <= r;
    column_i <= c;
    start    <= 1'b1;
    cfg_we_i <= 1'b0;
    do @(posedge clk_i); while (busy);
    pixel_expect_q.insert(pixel_expect_q.size(), expected);
  endtask

  task automatic send_predicted(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
    send_word(r, c, predict_pixel(kind_cfg, depth_cfg, r, c));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_KIND) kind_cfg = data[KIND_W-1:0];
    else if (idx == REG_DEPTH) depth_cfg = data[CFG_DEPTH_W-1:0];
  endtask

  // stop sending and wait for every outstanding word
  task automatic drain;
    start    <= 1'b0;
    cfg_we_i <= 1'b0;
    do @(posedge clk_i); while (pixel_expect_q.size() != 0);
  endtask

  task automatic note_error(string what, pixel_res_t exp_r, logic fill_a, logic out_a);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s: expected filled=%b outside=%b, got filled=%b outside=%b",
               $realtime, what, exp_r.filled, exp_r.outside, fill_a, out_a);
    end
  endtask

  always @(posedge clk_i) begin
    pixel_res_t exp_r;
    if (rst_ni && done_o) begin
      if (pixel_expect_q.size() == 0) begin
        exp_r.filled = 1'bx;
        exp_r.outside = 1'bx;
        note_error("word with nothing expected", exp_r, filled_o, outside_o);
      end else begin
        exp_r = pixel_expect_q.pop_front();
        if (filled_o !== exp_r.filled || outside_o !== exp_r.outside)
          note_error("result mismatch", exp_r, filled_o, outside_o);
      end
    end
  end

  initial begin
    #2_400_000;
    $display("tb_fractal_pixel_test_unit: done, errors");
    $finish;
  end

  initial begin
    int sent;
    int phase_words;
    int burst;
    int span;
    pixel_res_t typed_r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_steps[i].op == STEP_CFG) begin
        if (i == 0 || dir_steps[i-1].op != STEP_CFG) drain();
        write_reg(dir_steps[i].idx, dir_steps[i].data);
      end else if (dir_steps[i].typed) begin
        typed_r.filled = dir_steps[i].filled;
        typed_r.outside = dir_steps[i].outside;
        send_word(dir_steps[i].row, dir_steps[i].column, typed_r);
      end else begin
        send_predicted(dir_steps[i].row, dir_steps[i].column);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      drain();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_KIND, CFG_W'($urandom_range(0, 3)));
        write_reg(REG_DEPTH, CFG_W'($urandom_range(0, 7)));
      end else begin
        write_reg(REG_DEPTH, CFG_W'($urandom_range(0, 7)));
        write_reg(REG_KIND, CFG_W'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
      span = pattern_span(kind_cfg, depth_cfg);
      phase_words = $urandom_range(20, 80);
      while (phase_words > 0) begin
        burst = $urandom_range(1, 30);
        while (burst > 0 && phase_words > 0) begin
          send_predicted(pick_coord(span), pick_coord(span));
          burst--;
          phase_words--;
          sent++;
        end
        if ($urandom_range(0, 9) == 0) begin
          drain();
        end else if ($urandom_range(0, 3) != 0) begin
          start    <= 1'b0;
          cfg_we_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end

    drain();
    repeat (MAX_DEPTH + 4) @(posedge clk_i);
    if (mismatch_cnt == 0 && pixel_expect_q.size() == 0) begin
      $display("tb_fractal_pixel_test_unit: done, clean");
    end else begin
      $display("tb_fractal_pixel_test_unit: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fpt_pkg.sv
design/fpt_cell.sv
design/fractal_pixel_test_unit.sv
tb/sv/tb_fractal_pixel_test_unit.sv
